// File: rtl/core/axial_table_interp_radial_taper_assert.svh
// assertion macros for the axial table interpolator
// used by the rtl modules in this folder; needs clk and rst_n in scope
`ifndef AXIAL_TABLE_INTERP_RADIAL_TAPER_ASSERT_SVH
`define AXIAL_TABLE_INTERP_RADIAL_TAPER_ASSERT_SVH

// same-cycle implication
`define ATIRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ATIRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/atirt_pkg.sv
// shared types, constants and helper functions for the axial table interpolator
// no dependencies
`default_nettype none

package atirt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int TAPER_STEPS = 256;
  localparam int TAPER_W     = $clog2(TAPER_STEPS);
  localparam int ENTRY_W     = 32 + 32 + 31;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // 7/10 scaled by 2^34 and rounded up is 2^33 plus this
  localparam logic [32:0] SEVEN_TENTHS_LO = 33'h0_CCCC_CCCD;

  typedef logic [16:0] taper_rom_t [TAPER_STEPS];

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // cos^2 table in q1.16, built at elaboration
  function automatic taper_rom_t build_taper_rom();
    taper_rom_t      rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned tq;
    longint          c;
    longint unsigned cu;
    for (int k = 0; k < TAPER_STEPS; k++) begin
      x  = (PI_Q30 * longint'(k)) >> (TAPER_W + 1);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      c  = longint'(ONE_Q30);
      // series term n divides by (2n-1)*2n, odd terms subtract
      for (int n = 1; n <= 8; n++) begin
        tq = (t * x2) >> 30;
        unique case (n)
          1: begin t = tq / 64'd2;   c = c - longint'(t); end
          2: begin t = tq / 64'd12;  c = c + longint'(t); end
          3: begin t = tq / 64'd30;  c = c - longint'(t); end
          4: begin t = tq / 64'd56;  c = c + longint'(t); end
          5: begin t = tq / 64'd90;  c = c - longint'(t); end
          6: begin t = tq / 64'd132; c = c + longint'(t); end
          7: begin t = tq / 64'd182; c = c - longint'(t); end
          8: begin t = tq / 64'd240; c = c + longint'(t); end
          default: t = tq;
        endcase
      end
      if (c < 0) c = 0;
      if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
      cu     = longint'(c);
      rom[k] = 17'((cu * cu + (64'd1 << 43)) >> 44);
    end
    return rom;
  endfunction

  localparam taper_rom_t TAPER_ROM = build_taper_rom();

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // saturate a 35-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    if (v > 35'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -35'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // base value plus signed clamped quotient, saturated
  function automatic logic signed [31:0] interp_sum(input logic signed [31:0] base,
                                                    input logic [63:0] quo,
                                                    input logic neg);
    logic [33:0]        qc;
    logic signed [34:0] sum;
    qc  = (quo > 64'h2_0000_0000) ? 34'h2_0000_0000 : quo[33:0];
    sum = neg ? 35'(base) - 35'(signed'({1'b0, qc}))
              : 35'(base) + 35'(signed'({1'b0, qc}));
    return sat35(sum);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/atirt_table.sv
// entry store: axial position, conductivity and radius per slot
// one write port, one registered read port; uses atirt_pkg
`default_nettype none

module atirt_table
  import atirt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/atirt_div.sv
// shared restoring divider, one quotient bit per cycle
// uses atirt_pkg for the status struct
`default_nettype none

module atirt_div
  import atirt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output div_stat_t        stat,
  output logic      [63:0] quotient
);

  logic [33:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    trial    = {rem_r[32:0], quo_r[63]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start && !busy_r) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/axial_table_interp_radial_taper.sv
// top level: table load, interval search, interpolation and radial taper
// uses atirt_pkg, atirt_table, atirt_div and the assertion macro header
//
// channel  | dir | handshake            | payload
// in_      | in  | in_tvalid/in_tready  | tdata: index,axial,cond,radius,radial; tuser: kind
// out_     | out | out_tvalid/out_tready| tdata: conductivity,interval; tuser: ext,zero_span
// cfg_     | in  | cfg_wr_en            | cfg_wr_data: points in use
//
// a write transaction leaves in_tready high. a query keeps in_tready low until its result
// is handed to the output register; the end checks pick the interval, else a binary search
// of up to 6 steps does. the serial divider runs each interpolation and, inside the taper
// band, the rom index; the 0.7 scale is a multiply.
// reset is synchronous active low and clears control state only; table contents are
// undefined until written. a stalled output holds the block before its next transaction.
`default_nettype none
`include "axial_table_interp_radial_taper_assert.svh"

module axial_table_interp_radial_taper
  import atirt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [5:0] entry_index, [37:6] axial_position, [69:38] entry_conductivity,
  // [100:70] entry_radius, [131:101] radial_position, [135:132] zero
  input  wire logic [135:0] in_tdata,
  // [0] kind
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] conductivity, [37:32] interval_index, [39:38] zero
  output logic      [39:0]  out_tdata,
  // [0] extrapolated, [1] zero_span
  output logic      [1:0]   out_tuser,
  input  wire logic         cfg_wr_en,
  input  wire logic [6:0]   cfg_wr_data
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_A1  = 5'd1,  S_A0  = 5'd2,  S_AN  = 5'd3,
                         S_CHK  = 5'd4,  S_SRC = 5'd5,  S_SCM = 5'd6,  S_F0  = 5'd7,
                         S_F1   = 5'd8,  S_F2  = 5'd9,  S_MS  = 5'd10, S_DS  = 5'd11,
                         S_DWS  = 5'd12, S_MR  = 5'd13, S_DR  = 5'd14, S_DWR = 5'd15,
                         S_RC   = 5'd16, S_RCW = 5'd17, S_CMP = 5'd18, S_KW  = 5'd19,
                         S_TM   = 5'd20, S_TR  = 5'd21, S_OUT = 5'd22;

  logic [4:0] state_r, state_nxt;
  logic [6:0] points_r;

  logic [6:0]             n_r, n_nxt;
  logic signed [31:0]     z_r;
  logic [30:0]            r_r;
  logic signed [31:0]     x1_r, x0_r;
  logic [IDX_W-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt;
  logic [IDX_W-1:0]       mid_r;
  logic                   ext_r, ext_nxt;
  logic signed [31:0]     ax0_r, ax1_r, s0_r, s1_r;
  logic [30:0]            rd0_r, rd1_r;
  logic [63:0]            prod_r;
  logic signed [31:0]     sig_r;
  logic [30:0]            rad_r, rc_r;
  logic [16:0]            taper_r;
  logic signed [31:0]     res_r, res_nxt;
  logic                   out_tvalid_r;
  logic [31:0]            out_cond_r;
  logic [IDX_W-1:0]       out_idx_r;
  logic                   out_ext_r, out_zs_r;

  logic                   accept;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  logic signed [31:0]     rd_ax;
  logic [IDX_W-1:0]       n_m1, n_m2;
  logic [6:0]             mid_w;
  logic [IDX_W-1:0]       mid;

  logic signed [32:0]     dx, dz, dvs, dvr;
  logic                   zs;
  logic [32:0]            mul_a, mul_b;
  logic                   div_start;
  logic [63:0]            div_a;
  logic [32:0]            div_b;
  div_stat_t              div_stat;
  logic [63:0]            div_q;
  logic signed [31:0]     rad_i;
  logic [64:0]            rc_sum;
  logic [TAPER_W-1:0]     k_idx;
  logic [32:0]            p_w;
  logic signed [33:0]     p_s;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign rd_ax     = rd_data[31:0];
  assign n_m1      = IDX_W'(n_r - 7'd1);
  assign n_m2      = IDX_W'(n_r - 7'd2);
  assign mid_w     = 7'(lo_r) + ((7'(hi_r) - 7'(lo_r) + 7'd1) >> 1);
  assign mid       = mid_w[IDX_W-1:0];

  assign dx  = 33'(ax1_r) - 33'(ax0_r);
  assign dz  = 33'(z_r) - 33'(ax0_r);
  assign dvs = 33'(s1_r) - 33'(s0_r);
  assign dvr = 33'(signed'({2'b0, rd1_r})) - 33'(signed'({2'b0, rd0_r}));
  assign zs  = (ax1_r == ax0_r);

  atirt_table u_table (
    .clk     (clk),
    .wr_en   (accept && !in_tuser[0]),
    .wr_addr (in_tdata[5:0]),
    .wr_data ({in_tdata[100:70], in_tdata[69:38], in_tdata[37:6]}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  atirt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    unique case (state_r)
      S_A1:    rd_addr = IDX_W'(1);
      S_AN:    rd_addr = n_m1;
      S_SRC:   rd_addr = mid;
      S_F0:    rd_addr = i_r;
      S_F1:    rd_addr = i_r + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MS:    begin mul_a = mag33(dvs); mul_b = mag33(dz); end
      S_MR:    begin mul_a = mag33(dvr); mul_b = mag33(dz); end
      S_RC:    begin mul_a = {2'b0, rad_r}; mul_b = SEVEN_TENTHS_LO; end
      default: begin mul_a = mag33(33'(sig_r)); mul_b = {16'b0, taper_r}; end
    endcase
  end

  // shared divider operand select
  always_comb begin
    div_start = 1'b0;
    unique case (state_r)
      S_DS, S_DR: begin
        div_start = 1'b1;
        div_a     = prod_r;
        div_b     = mag33(dx);
      end
      default: begin
        div_start = (state_r == S_CMP) && (r_r > rc_r) && (r_r < rad_r);
        div_a     = {25'b0, r_r - rc_r, {TAPER_W{1'b0}}};
        div_b     = 33'(rad_r - rc_r);
      end
    endcase
  end

  assign rad_i  = interp_sum(signed'({1'b0, rd0_r}), div_q,
                             ((dvr[32] != dz[32]) != dx[32]));
  // floor(7r/10) as (r * 2^33 + r * low part) >> 34
  assign rc_sum = {1'b0, rad_r, 33'b0} + {1'b0, prod_r};
  assign k_idx  = (div_q >= 64'(TAPER_STEPS)) ? TAPER_W'(TAPER_STEPS - 1)
                                              : div_q[TAPER_W-1:0];
  assign p_w    = 33'((prod_r + 64'd32768) >> 16);
  assign p_s    = sig_r[31] ? -34'(signed'({1'b0, p_w})) : 34'(signed'({1'b0, p_w}));

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    ext_nxt   = ext_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_tuser[0]) begin
          priority if (points_r < 7'd2) n_nxt = 7'd2;
          else if (points_r > 7'(TABLE_DEPTH)) n_nxt = 7'(TABLE_DEPTH);
          else n_nxt = points_r;
          state_nxt = S_A1;
        end
      end
      S_A1: state_nxt = S_A0;
      S_A0: state_nxt = S_AN;
      S_AN: state_nxt = S_CHK;
      S_CHK: begin
        ext_nxt = (z_r < x0_r) || (z_r > rd_ax);
        priority if (z_r < x1_r) begin
          i_nxt     = '0;
          state_nxt = S_F0;
        end else if (z_r > rd_ax) begin
          i_nxt     = n_m2;
          state_nxt = S_F0;
        end else begin
          lo_nxt    = IDX_W'(1);
          hi_nxt    = n_m1;
          state_nxt = S_SRC;
        end
      end
      S_SRC: begin
        if (7'(hi_r) > 7'(lo_r) + 7'd1) begin
          state_nxt = S_SCM;
        end else begin
          i_nxt     = (lo_r > n_m2) ? n_m2 : lo_r;
          state_nxt = S_F0;
        end
      end
      S_SCM: begin
        priority if (z_r == rd_ax) begin
          i_nxt     = (mid_r > n_m2) ? n_m2 : mid_r;
          state_nxt = S_F0;
        end else if (z_r < rd_ax) begin
          hi_nxt    = mid_r;
          state_nxt = S_SRC;
        end else begin
          lo_nxt    = mid_r;
          state_nxt = S_SRC;
        end
      end
      S_F0:  state_nxt = S_F1;
      S_F1:  state_nxt = S_F2;
      S_F2:  state_nxt = S_MS;
      S_MS:  state_nxt = S_DS;
      S_DS:  state_nxt = S_DWS;
      S_DWS: if (div_stat.done) state_nxt = S_MR;
      S_MR:  state_nxt = S_DR;
      S_DR:  state_nxt = S_DWR;
      S_DWR: if (div_stat.done) state_nxt = S_RC;
      S_RC:  state_nxt = S_RCW;
      S_RCW: state_nxt = S_CMP;
      S_CMP: begin
        priority if (r_r <= rc_r) begin
          res_nxt   = sig_r;
          state_nxt = S_OUT;
        end else if (r_r < rad_r) begin
          state_nxt = S_KW;
        end else begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_KW:  if (div_stat.done) state_nxt = S_TM;
      S_TM:  state_nxt = S_TR;
      S_TR: begin
        if (p_s > 34'sh0_7FFF_FFFF) res_nxt = 32'sh7FFF_FFFF;
        else res_nxt = p_s[31:0];
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      points_r     <= 7'(TABLE_DEPTH);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) points_r <= cfg_wr_data;
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    i_r   <= i_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    ext_r <= ext_nxt;
    res_r <= res_nxt;
    if (state_r == S_SRC) mid_r <= mid;
    if (accept) begin
      z_r <= in_tdata[37:6];
      r_r <= in_tdata[131:101];
    end
    if (state_r == S_A0) x1_r <= rd_ax;
    if (state_r == S_AN) x0_r <= rd_ax;
    if (state_r == S_F1) begin
      ax0_r <= rd_data[31:0];
      s0_r  <= rd_data[63:32];
      rd0_r <= rd_data[94:64];
    end
    if (state_r == S_F2) begin
      ax1_r <= rd_data[31:0];
      s1_r  <= rd_data[63:32];
      rd1_r <= rd_data[94:64];
    end
    if (state_r == S_MS || state_r == S_MR || state_r == S_RC || state_r == S_TM) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
    if (state_r == S_DWS && div_stat.done) begin
      sig_r <= zs ? s0_r : interp_sum(s0_r, div_q, ((dvs[32] != dz[32]) != dx[32]));
    end
    if (state_r == S_DWR && div_stat.done) begin
      if (zs) rad_r <= rd0_r;
      else rad_r <= rad_i[31] ? 31'd0 : rad_i[30:0];
    end
    if (state_r == S_RCW) rc_r <= rc_sum[64:34];
    if (state_r == S_KW && div_stat.done) taper_r <= TAPER_ROM[k_idx];
    if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
      out_cond_r <= res_r;
      out_idx_r  <= i_r;
      out_ext_r  <= ext_r;
      out_zs_r   <= zs;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b0, out_idx_r, out_cond_r};
  assign out_tuser  = {out_zs_r, out_ext_r};

  `ATIRT_ASSERT_NEXT(a_query_blocks, accept && in_tuser[0], !in_tready, "query did not hold off input")
  `ATIRT_ASSERT_NOW(a_search_order, state_r == S_SRC || state_r == S_SCM, lo_r <= hi_r, "search bounds crossed")
  `ATIRT_ASSERT_NOW(a_interval_range, state_r == S_F0, i_r <= n_m2, "interval index past last interval")
  `ATIRT_ASSERT_NOW(a_div_free, div_start, !div_stat.busy, "divider started while busy")

endmodule

`default_nettype wire
